// File: hw/rtl/brb_pkg.sv
// shared constants and types of the byte ring buffer
package brb_pkg;

   localparam int DEPTH  = 256;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      OP_WRITE    = 3'd0,
      OP_PEEK     = 3'd1,
      OP_SEARCH   = 3'd2,
      OP_CHECKSUM = 3'd3,
      OP_DISCARD  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_OVERWROTE   = 2'd1,
      ST_MISS        = 2'd2,
      ST_OVERDISCARD = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_READ,
      S_ACC,
      S_DONE
   } state_type;

endpackage

// File: hw/rtl/brb_if.sv
// request and response channel interfaces of the byte ring buffer
interface brb_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [7:0]  byte_value;
   logic [15:0] start_offset;
   logic [15:0] end_offset;
   logic [15:0] discard_count;

   modport source (output valid, op, byte_value, start_offset, end_offset, discard_count,
                   input ready);
   modport sink   (input valid, op, byte_value, start_offset, end_offset, discard_count,
                   output ready);
endinterface

interface brb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  read_byte;
   logic [15:0] found_offset;
   logic [7:0]  sum_byte;
   logic [8:0]  fill_count;

   modport source (output valid, status, read_byte, found_offset, sum_byte, fill_count,
                   input ready);
   modport sink   (input valid, status, read_byte, found_offset, sum_byte, fill_count,
                   output ready);
endinterface

// File: hw/rtl/brb_ram.sv
// generic single write port, single read port ram with registered read
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/byte_ring_buffer_search_checksum.sv
// byte ring buffer with overwrite, peek, search, checksum and discard
//
// req carries one operation per beat, rsp returns exactly one result beat
// per operation. req.ready is high only while the sequencer is idle; one
// operation is worked at a time.
// a beat is taken into a holding register and dispatched in the next cycle;
// its result is held in the result registers and loaded into the rsp output
// register from the done state once that register is free. write, discard,
// unused codes and out-of-range requests go from dispatch straight to done.
// peek, search and checksum scan the store through the single ram read port,
// with a read state and an accumulate state per byte examined, up to DEPTH
// bytes; a search stops at its first match.
// the position adder (add with wrap at DEPTH) is shared by every pointer
// advance and by the scan address step.
// while a result waits in the rsp register the block takes the next beat and
// works it; it holds before loading the following result until the waiting
// beat is taken.
// reset empties the buffer (head, tail, fill all zero) and drops any pending
// result; store contents are not cleared.
module byte_ring_buffer_search_checksum
   import brb_pkg::*;
(
   input logic   clock,
   input logic   reset,
   brb_req_if.sink   req,
   brb_rsp_if.source rsp
);

   localparam logic [ADDR_W:0] DEPTH_A = (ADDR_W + 1)'(DEPTH);
   localparam logic [16:0]     DEPTH_L = 17'(DEPTH);

   state_type         state_ff, state_in;
   op_type            op_ff;
   logic [7:0]        val_ff;
   logic [15:0]       start_ff, end_ff, dcount_ff;
   logic [ADDR_W-1:0] head_ff, head_in, tail_ff, tail_in, pos_ff, pos_in;
   logic [CNT_W-1:0]  held_ff, held_in, idx_ff, idx_in, limit_ff, limit_in;
   logic [7:0]        acc_ff, acc_in, res_byte_ff, res_byte_in;
   logic [15:0]       res_found_ff, res_found_in;
   status_type        res_status_ff, res_status_in;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [7:0]        rsp_byte_ff, rsp_sum_ff;
   logic [15:0]       rsp_found_ff;
   logic [8:0]        rsp_fill_ff;

   logic [ADDR_W-1:0] unit_a, unit_y;
   logic [ADDR_W:0]   unit_b, unit_sum;

   logic              ram_wr_en, ram_rd_en;
   logic [7:0]        ram_rd_data;

   logic [15:0]       held16;
   logic              start_miss, cks_bad, scan_end, hit, out_free, load_rsp;

   // shared position adder with wrap
   assign unit_sum = {1'b0, unit_a} + unit_b;
   assign unit_y   = (unit_sum >= DEPTH_A) ? ADDR_W'(unit_sum - DEPTH_A) : ADDR_W'(unit_sum);

   assign held16     = 16'(held_ff);
   assign start_miss = start_ff >= held16;
   assign cks_bad    = start_miss || (end_ff > held16) || (start_ff > end_ff);
   assign scan_end   = idx_ff == limit_ff;
   assign hit        = ram_rd_data == val_ff;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign load_rsp   = (state_ff == S_DONE) && out_free;

   assign req.ready = state_ff == S_IDLE;

   brb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (val_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (op_ff)
               OP_PEEK, OP_SEARCH: state_in = start_miss ? S_DONE : S_READ;
               OP_CHECKSUM:        state_in = cks_bad ? S_DONE : S_READ;
               default:            state_in = S_DONE;
            endcase
         end
         S_READ: begin
            state_in = scan_end ? S_DONE : S_ACC;
         end
         S_ACC: begin
            if (op_ff == OP_PEEK || (op_ff == OP_SEARCH && hit)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      held_in       = held_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      limit_in      = limit_ff;
      acc_in        = acc_ff;
      res_byte_in   = res_byte_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      unit_a        = pos_ff;
      unit_b        = (ADDR_W + 1)'(1);
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      case (state_ff)
         S_DISPATCH: begin
            acc_in        = 8'd0;
            res_byte_in   = 8'd0;
            res_found_in  = 16'd0;
            res_status_in = ST_OK;
            unit_a        = head_ff;
            unit_b        = (ADDR_W + 1)'(start_ff);
            pos_in        = unit_y;
            idx_in        = CNT_W'(start_ff);
            case (op_ff)
               OP_WRITE: begin
                  ram_wr_en = 1'b1;
                  unit_a    = tail_ff;
                  unit_b    = (ADDR_W + 1)'(1);
                  tail_in   = unit_y;
                  if (held_ff == CNT_W'(DEPTH)) begin
                     head_in       = unit_y;
                     res_status_in = ST_OVERWROTE;
                  end else begin
                     held_in = held_ff + CNT_W'(1);
                  end
               end
               OP_PEEK: begin
                  limit_in = CNT_W'(start_ff) + CNT_W'(1);
                  if (start_miss) begin
                     res_status_in = ST_MISS;
                  end
               end
               OP_SEARCH: begin
                  limit_in = held_ff;
                  if (start_miss) begin
                     res_status_in = ST_MISS;
                  end
               end
               OP_CHECKSUM: begin
                  limit_in = CNT_W'(end_ff);
                  if (cks_bad) begin
                     res_status_in = ST_MISS;
                  end
               end
               OP_DISCARD: begin
                  unit_b = (ADDR_W + 1)'(dcount_ff);
                  if ({1'b0, dcount_ff} > DEPTH_L) begin
                     res_status_in = ST_OVERDISCARD;
                  end
                  if (held_ff != '0) begin
                     if (dcount_ff >= held16) begin
                        head_in = '0;
                        tail_in = '0;
                        held_in = '0;
                     end else begin
                        head_in = unit_y;
                        held_in = held_ff - CNT_W'(dcount_ff);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            if (scan_end) begin
               if (op_ff == OP_SEARCH) begin
                  res_status_in = ST_MISS;
               end
            end else begin
               ram_rd_en = 1'b1;
            end
         end
         S_ACC: begin
            idx_in = idx_ff + CNT_W'(1);
            pos_in = unit_y;
            case (op_ff)
               OP_PEEK:     res_byte_in = ram_rd_data;
               OP_SEARCH: begin
                  if (hit) begin
                     res_found_in = 16'(idx_ff);
                  end
               end
               OP_CHECKSUM: acc_in = acc_ff + ram_rd_data;
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         held_ff  <= held_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         op_ff     <= op_type'(req.op);
         val_ff    <= req.byte_value;
         start_ff  <= req.start_offset;
         end_ff    <= req.end_offset;
         dcount_ff <= req.discard_count;
      end
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      limit_ff      <= limit_in;
      acc_ff        <= acc_in;
      res_byte_ff   <= res_byte_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_byte_ff   <= res_byte_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_sum_ff    <= acc_ff;
         rsp_fill_ff   <= 9'(held_ff);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.read_byte    = rsp_byte_ff;
   assign rsp.found_offset = rsp_found_ff;
   assign rsp.sum_byte     = rsp_sum_ff;
   assign rsp.fill_count   = rsp_fill_ff;

endmodule

// File: test/tb.sv
// testbench for the byte ring buffer: queued driver, checking monitor and cycle watchdog
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import brb_pkg::*;

   localparam int RANDOM_ITEMS   = 1750;
   localparam int OP_CODE_MAX    = 7;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 600;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int MAX_REPORTS    = 30;

   typedef struct {
      logic [2:0]  op;
      logic [7:0]  byte_value;
      logic [15:0] start_offset;
      logic [15:0] end_offset;
      logic [15:0] discard_count;
      int          gap;
      bit          drain;
   } ring_cmd_type;

   typedef struct {
      status_type  status;
      logic [7:0]  read_byte;
      logic [15:0] found_offset;
      logic [7:0]  sum_byte;
      logic [8:0]  fill_count;
   } ring_result_type;

   logic clock;
   logic reset = 1'b1;

   brb_req_if req_ch ();
   brb_rsp_if rsp_ch ();

   byte_ring_buffer_search_checksum dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   ring_cmd_type    cmd_queue[$];
   ring_result_type predicted_rsp[$];

   // shadow of the buffer
   logic [7:0] ring_mem [DEPTH];
   int         ring_head = 0;
   int         ring_fill = 0;

   // fill level as seen while building stimulus
   int gen_fill = 0;

   int beats_in = 0;
   int beats_out = 0;
   int mismatches = 0;
   int overwrites = 0;
   int misses = 0;
   int clamped = 0;

   function automatic ring_result_type ring_apply(input ring_cmd_type c);
      ring_result_type r;
      int              n;
      bit              hit;
      logic [7:0]      acc;
      r.status       = ST_OK;
      r.read_byte    = 8'h00;
      r.found_offset = 16'h0000;
      r.sum_byte     = 8'h00;
      case (c.op)
         OP_WRITE: begin
            ring_mem[(ring_head + ring_fill) % DEPTH] = c.byte_value;
            if (ring_fill >= DEPTH) begin
               ring_head = (ring_head + 1) % DEPTH;
               r.status  = ST_OVERWROTE;
            end else begin
               ring_fill++;
            end
         end
         OP_PEEK: begin
            if (c.start_offset >= ring_fill) r.status = ST_MISS;
            else r.read_byte = ring_mem[(ring_head + c.start_offset) % DEPTH];
         end
         OP_SEARCH: begin
            hit = 1'b0;
            for (int i = c.start_offset; i < ring_fill; i++) begin
               if (!hit && ring_mem[(ring_head + i) % DEPTH] == c.byte_value) begin
                  hit            = 1'b1;
                  r.found_offset = 16'(i);
               end
            end
            if (!hit) r.status = ST_MISS;
         end
         OP_CHECKSUM: begin
            if (c.start_offset >= ring_fill || c.end_offset > ring_fill ||
                c.start_offset > c.end_offset) begin
               r.status = ST_MISS;
            end else begin
               acc = 8'h00;
               for (int i = c.start_offset; i < c.end_offset; i++)
                  acc = acc + ring_mem[(ring_head + i) % DEPTH];
               r.sum_byte = acc;
            end
         end
         OP_DISCARD: begin
            n = c.discard_count;
            if (n > DEPTH) begin
               n        = DEPTH;
               r.status = ST_OVERDISCARD;
            end
            if (ring_fill > 0) begin
               if (n >= ring_fill) begin
                  ring_head = 0;
                  ring_fill = 0;
               end else begin
                  ring_head = (ring_head + n) % DEPTH;
                  ring_fill = ring_fill - n;
               end
            end
         end
         default: begin
         end
      endcase
      r.fill_count = 9'(ring_fill);
      return r;
   endfunction

   function automatic string show_result(input ring_result_type r);
      return $sformatf("status=%0d read=%0h found=%0d sum=%0h fill=%0d", r.status,
                       r.read_byte, r.found_offset, r.sum_byte, r.fill_count);
   endfunction

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic logic [15:0] pick_offset();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 8) return 16'($urandom_range(0, gen_fill + 1));
      if (sel == 8) return 16'((gen_fill > 0) ? gen_fill - 1 : 0);
      return 16'($urandom);
   endfunction

   task automatic push_cmd(input logic [2:0] op, input logic [7:0] v, input logic [15:0] s,
                           input logic [15:0] e, input logic [15:0] d, input bit drain);
      ring_cmd_type c;
      int           n;
      c.op            = op;
      c.byte_value    = v;
      c.start_offset  = s;
      c.end_offset    = e;
      c.discard_count = d;
      c.drain         = drain;
      c.gap           = draw_gap(((cmd_queue.size() / 120) % 5) == 2);
      cmd_queue.push_back(c);
      if (op == OP_WRITE) begin
         if (gen_fill < DEPTH) gen_fill++;
      end else if (op == OP_DISCARD) begin
         n = (d > DEPTH) ? DEPTH : d;
         gen_fill = (n >= gen_fill) ? 0 : gen_fill - n;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // driver
   ring_cmd_type    staged;
   bit              staged_ok = 1'b0;
   int              stage_wait = 0;
   ring_cmd_type    taken;
   ring_result_type taken_rsp;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid         <= 1'b0;
         req_ch.op            <= OP_WRITE;
         req_ch.byte_value    <= 8'h00;
         req_ch.start_offset  <= 16'h0000;
         req_ch.end_offset    <= 16'h0000;
         req_ch.discard_count <= 16'h0000;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            taken.op            = req_ch.op;
            taken.byte_value    = req_ch.byte_value;
            taken.start_offset  = req_ch.start_offset;
            taken.end_offset    = req_ch.end_offset;
            taken.discard_count = req_ch.discard_count;
            taken_rsp = ring_apply(taken);
            predicted_rsp.push_back(taken_rsp);
            beats_in++;
            if (taken_rsp.status == ST_OVERWROTE) overwrites++;
            if (taken_rsp.status == ST_MISS) misses++;
            if (taken_rsp.status == ST_OVERDISCARD) clamped++;
         end
         if (!staged_ok && cmd_queue.size() > 0) begin
            staged     = cmd_queue.pop_front();
            staged_ok  = 1'b1;
            stage_wait = staged.gap;
         end
         if (staged_ok && stage_wait == 0 && !(staged.drain && predicted_rsp.size() != 0)) begin
            req_ch.op            <= staged.op;
            req_ch.byte_value    <= staged.byte_value;
            req_ch.start_offset  <= staged.start_offset;
            req_ch.end_offset    <= staged.end_offset;
            req_ch.discard_count <= staged.discard_count;
            req_ch.valid         <= 1'b1;
            staged_ok = 1'b0;
         end else begin
            req_ch.valid <= 1'b0;
            if (staged_ok && stage_wait > 0) stage_wait--;
         end
      end
   end

   // monitor
   int              rsp_wait = 0;
   ring_result_type want;
   ring_result_type got;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            beats_out++;
            got.status       = status_type'(rsp_ch.status);
            got.read_byte    = rsp_ch.read_byte;
            got.found_offset = rsp_ch.found_offset;
            got.sum_byte     = rsp_ch.sum_byte;
            got.fill_count   = rsp_ch.fill_count;
            if (predicted_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: unexpected beat, expected none, actual %s", $time,
                           show_result(got));
            end else begin
               want = predicted_rsp.pop_front();
               if (got.status !== want.status || got.read_byte !== want.read_byte ||
                   got.found_offset !== want.found_offset ||
                   got.sum_byte !== want.sum_byte || got.fill_count !== want.fill_count) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: beat %0d expected %s, actual %s", $time, beats_out,
                              show_result(want), show_result(got));
               end
            end
            if (beats_out == 400 || beats_out == 1000 || beats_out == 1400)
               rsp_wait = LONG_HOLD;
            else
               rsp_wait = draw_gap(((beats_out / 150) % 4) == 1);
         end
         if (rsp_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, idle_cycles);
         $display("byte_ring_buffer_search_checksum: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int          pick;
      int          mix;
      int          w;
      int          dsc;
      logic [15:0] s;
      logic [15:0] e;
      logic [15:0] d;

      // directed: empty buffer, field extremes, every op and its corner cases
      push_cmd(OP_PEEK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      push_cmd(OP_SEARCH, 8'h00, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
      push_cmd(OP_CHECKSUM, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      push_cmd(OP_DISCARD, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      push_cmd(OP_DISCARD, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      push_cmd(OP_WRITE, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      push_cmd(OP_WRITE, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      push_cmd(OP_WRITE, 8'h5A, 16'hA5A5, 16'h5A5A, 16'hA5A5, 1'b0);
      push_cmd(OP_WRITE, 8'hA5, 16'h5A5A, 16'hA5A5, 16'h5A5A, 1'b0);
      push_cmd(OP_PEEK, 8'h00, 16'd0, 16'h0000, 16'h0000, 1'b0);
      push_cmd(OP_PEEK, 8'h00, 16'd3, 16'h0000, 16'h0000, 1'b0);
      push_cmd(OP_PEEK, 8'h00, 16'd4, 16'h0000, 16'h0000, 1'b0);
      push_cmd(OP_PEEK, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
      push_cmd(OP_SEARCH, 8'hFF, 16'd0, 16'h0000, 16'h0000, 1'b0);
      push_cmd(OP_SEARCH, 8'hFF, 16'd2, 16'h0000, 16'h0000, 1'b0);
      push_cmd(OP_SEARCH, 8'h5A, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
      push_cmd(OP_CHECKSUM, 8'h00, 16'd0, 16'd4, 16'h0000, 1'b0);
      push_cmd(OP_CHECKSUM, 8'h00, 16'd2, 16'd2, 16'h0000, 1'b0);
      push_cmd(OP_CHECKSUM, 8'h00, 16'd3, 16'd1, 16'h0000, 1'b0);
      push_cmd(OP_CHECKSUM, 8'h00, 16'd1, 16'd5, 16'h0000, 1'b0);
      push_cmd(OP_CHECKSUM, 8'h00, 16'd4, 16'd4, 16'h0000, 1'b0);
      push_cmd(OP_DISCARD, 8'h00, 16'h0000, 16'h0000, 16'd1, 1'b0);
      push_cmd(3'(OP_DISCARD + 1), 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      push_cmd(3'(OP_DISCARD + 2), 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      push_cmd(3'(OP_CODE_MAX), 8'hA5, 16'h5A5A, 16'hA5A5, 16'h5A5A, 1'b0);
      push_cmd(OP_DISCARD, 8'h00, 16'h0000, 16'h0000, 16'(DEPTH + 1), 1'b0);

      // random: phases that fill past full, mix everything, then drain
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         mix  = (k / 300) % 3;
         w    = (mix == 0) ? 94 : (mix == 1) ? 45 : 20;
         dsc  = (mix == 0) ? 0 : (mix == 1) ? 6 : 15;
         pick = $urandom_range(0, 99);
         if (pick < w) begin
            push_cmd(OP_WRITE,
                     ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), (k % 300) == 0);
         end else if (pick < w + dsc) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: d = 16'($urandom_range(0, gen_fill / 3 + 1));
               6, 7:             d = 16'($urandom_range(0, gen_fill + 1));
               8:                d = 16'($urandom_range(DEPTH - 2, DEPTH + 2));
               default:          d = 16'($urandom);
            endcase
            push_cmd(OP_DISCARD, 8'($urandom), 16'($urandom), 16'($urandom), d, (k % 300) == 0);
         end else if (pick >= 97) begin
            push_cmd(3'($urandom_range(OP_DISCARD + 1, OP_CODE_MAX)), 8'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), (k % 300) == 0);
         end else begin
            case (pick % 3)
               0: push_cmd(OP_PEEK, 8'($urandom), pick_offset(), 16'($urandom), 16'($urandom),
                           (k % 300) == 0);
               1: push_cmd(OP_SEARCH,
                           ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 7)) : 8'($urandom),
                           pick_offset(), 16'($urandom), 16'($urandom), (k % 300) == 0);
               default: begin
                  if ($urandom_range(0, 3) != 0) begin
                     s = 16'($urandom_range(0, gen_fill));
                     e = 16'($urandom_range(s, gen_fill));
                  end else if ($urandom_range(0, 1) != 0) begin
                     s = 16'($urandom);
                     e = 16'($urandom);
                  end else begin
                     s = 16'($urandom_range(0, gen_fill + 2));
                     e = 16'($urandom_range(0, gen_fill + 2));
                  end
                  push_cmd(OP_CHECKSUM, 8'($urandom), s, e, 16'($urandom), (k % 300) == 0);
               end
            endcase
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || staged_ok || req_ch.valid || predicted_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (predicted_rsp.size() != 0) begin
         mismatches++;
         $display("%0t: expected %0d more beats, actual 0", $time, predicted_rsp.size());
      end
      $display("run covered %0d requests and %0d result beats", beats_in, beats_out);
      $display("%0d overwrites, %0d misses, %0d clamped discards, %0d mismatches",
               overwrites, misses, clamped, mismatches);
      if (mismatches == 0) begin
         $display("byte_ring_buffer_search_checksum: match");
      end else begin
         $display("byte_ring_buffer_search_checksum: mismatch");
      end
      $finish;
   end

endmodule
